### design/swept_circle_box_hit_time_defines.svh
// assertion macros shared by the swept circle hit-time block
// sch_assert_now checks cons in the cycle where ante holds
// sch_assert_next checks cons in the cycle after ante holds
`ifndef SWEPT_CIRCLE_BOX_HIT_TIME_DEFINES_SVH
`define SWEPT_CIRCLE_BOX_HIT_TIME_DEFINES_SVH

`ifndef SYNTH

`define SCH_ASSERT_NOW(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`define SCH_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCH_ASSERT_NOW(lbl, clk_sig, rst_sig, ante, cons, msg)

`define SCH_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

### design/sch_pkg.sv
//------------------------------------------------------------------------------
// sch_pkg
// Shared constants, flag bundle and helpers for the swept circle hit-time block.
//------------------------------------------------------------------------------
`default_nettype none

package sch_pkg;

  localparam int RADIUS_BITS        = 12;
  localparam int COORD_BITS_DEF     = 16;
  localparam int TIME_FRAC_BITS_DEF = 16;

  // 9.0 pixels in q8.4
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd144;

  // per-transaction flags that ride alongside the quotient pipeline
  typedef struct packed {
    logic static_miss;  // start outside the slab on an axis with no motion
    logic move_x;
    logic move_y;
  } sch_flags_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### design/sch_prep.sv
//------------------------------------------------------------------------------
// sch_prep
// Two register stages: grown slab bounds and motion, then slab-relative
// numerators, axis denominators and the static-axis miss flags.
//------------------------------------------------------------------------------
`default_nettype none

module sch_prep import sch_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic signed [COORD_BITS-1:0]    from_x,
  input  wire logic signed [COORD_BITS-1:0]    from_y,
  input  wire logic signed [COORD_BITS-1:0]    to_x,
  input  wire logic signed [COORD_BITS-1:0]    to_y,
  input  wire logic signed [COORD_BITS-1:0]    box_left,
  input  wire logic signed [COORD_BITS-1:0]    box_top,
  input  wire logic        [COORD_BITS-2:0]    box_width,
  input  wire logic        [COORD_BITS-2:0]    box_height,
  input  wire logic        [RADIUS_BITS-1:0]   radius,
  output logic                                 out_valid,
  output logic signed [imax(COORD_BITS, RADIUS_BITS)+2:0] num [4],
  output logic signed [COORD_BITS:0]           den [2],
  output sch_flags_t                           flags
);

  localparam int WIDE  = imax(COORD_BITS, RADIUS_BITS);
  localparam int BND_W = WIDE + 2;
  localparam int NUM_W = WIDE + 3;
  localparam int DLT_W = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] from_a [2];
  logic signed [COORD_BITS-1:0] to_a   [2];
  logic signed [COORD_BITS-1:0] edge_a [2];
  logic        [COORD_BITS-2:0] size_a [2];

  logic signed [COORD_BITS-1:0] start_r [2];
  logic signed [DLT_W-1:0]      delta_r [2];
  logic signed [BND_W-1:0]      lo_r    [2];
  logic signed [BND_W-1:0]      hi_r    [2];
  logic                         v1;

  logic [1:0] outside;

  always_comb begin
    from_a[0] = from_x;
    from_a[1] = from_y;
    to_a[0]   = to_x;
    to_a[1]   = to_y;
    edge_a[0] = box_left;
    edge_a[1] = box_top;
    size_a[0] = box_width;
    size_a[1] = box_height;
  end

  // stage 1: grow the box by the radius and take the motion
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        start_r[k] <= from_a[k];
        delta_r[k] <= DLT_W'(to_a[k]) - DLT_W'(from_a[k]);
        lo_r[k]    <= BND_W'(edge_a[k]) - BND_W'(radius);
        hi_r[k]    <= BND_W'(edge_a[k]) + BND_W'(size_a[k]) + BND_W'(radius);
      end
    end
  end

  // stage 2: distances from the start to both slab bounds
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      outside[k] = (BND_W'(start_r[k]) < lo_r[k]) || (BND_W'(start_r[k]) > hi_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        num[2*k]   <= NUM_W'(lo_r[k]) - NUM_W'(start_r[k]);
        num[2*k+1] <= NUM_W'(hi_r[k]) - NUM_W'(start_r[k]);
        den[k]     <= delta_r[k];
      end
      flags.move_x      <= (delta_r[0] != '0);
      flags.move_y      <= (delta_r[1] != '0);
      flags.static_miss <= ((delta_r[0] == '0) && outside[0]) ||
                           ((delta_r[1] == '0) && outside[1]);
    end
  end

endmodule

`default_nettype wire

### design/sch_div.sv
//------------------------------------------------------------------------------
// sch_div
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Gives trunc(num * 2^frac / den) saturated to +-2.0 for each slab bound.
//------------------------------------------------------------------------------
`default_nettype none

`include "swept_circle_box_hit_time_defines.svh"

module sch_div import sch_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            en,
  input  wire logic                                            in_valid,
  input  wire sch_flags_t                                      in_flags,
  input  wire logic signed [imax(COORD_BITS, RADIUS_BITS)+2:0] num [4],
  input  wire logic signed [COORD_BITS:0]                      den [2],
  output logic                                                 out_valid,
  output sch_flags_t                                           out_flags,
  output logic signed [TIME_FRAC_BITS+2:0]                     quo [4]
);

  localparam int WIDE  = imax(COORD_BITS, RADIUS_BITS);
  localparam int NUM_W = WIDE + 3;
  localparam int DEN_W = COORD_BITS + 1;
  localparam int MAG_W = NUM_W - 1;
  localparam int DIV_W = COORD_BITS + 2;   // four times the divisor
  localparam int RW    = COORD_BITS + 3;   // doubled partial remainder
  localparam int CMP_W = imax(MAG_W, DIV_W);
  localparam int QW    = TIME_FRAC_BITS + 2;
  localparam int TW    = TIME_FRAC_BITS + 3;

  localparam logic [QW-1:0]        SAT    = {1'b1, {(TIME_FRAC_BITS+1){1'b0}}};
  localparam logic signed [TW-1:0] SAT_S  = TW'(SAT);
  localparam logic signed [TW-1:0] NSAT_S = -SAT_S;

  logic [RW-1:0]    rem  [QW+1][4];
  logic [QW-1:0]    quot [QW+1][4];
  logic [DIV_W-1:0] dsh  [QW+1][2];
  logic             neg  [QW+1][4];
  logic             ovf  [QW+1][4];
  logic             vld  [QW+1];
  sch_flags_t       flg  [QW+1];

  // entry stage: magnitudes, result sign and the out-of-range check
  logic [COORD_BITS-1:0] dmag [2];
  logic [DIV_W-1:0]      d4   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dmag[a] = den[a][DEN_W-1] ? COORD_BITS'(-den[a]) : COORD_BITS'(den[a]);
      d4[a]   = {dmag[a], 2'b00};
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_entry
    logic [NUM_W-1:0] mag_full;
    logic [MAG_W-1:0] mag;

    assign mag_full = num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]);
    assign mag      = mag_full[MAG_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        // a quotient of 2^(frac+2) or more saturates regardless of the low bits
        ovf[0][k]  <= CMP_W'(mag) >= CMP_W'(d4[k >> 1]);
        rem[0][k]  <= RW'(mag[DIV_W-1:0]);
        quot[0][k] <= '0;
        neg[0][k]  <= num[k][NUM_W-1] ^ den[k >> 1][DEN_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsh[0][0] <= d4[0];
      dsh[0][1] <= d4[1];
      flg[0]    <= in_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // one quotient bit per stage against 4*den with the remainder kept below it
  for (genvar s = 0; s < QW; s++) begin : g_step
    for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [RW-1:0] r2;
      logic          take;

      assign r2   = {rem[s][k][RW-2:0], 1'b0};
      assign take = r2 >= RW'(dsh[s][k >> 1]);

      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1][k]  <= take ? (r2 - RW'(dsh[s][k >> 1])) : r2;
          quot[s+1][k] <= {quot[s][k][QW-2:0], take};
          neg[s+1][k]  <= neg[s][k];
          ovf[s+1][k]  <= ovf[s][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsh[s+1][0] <= dsh[s][0];
        dsh[s+1][1] <= dsh[s][1];
        flg[s+1]    <= flg[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
  end

  // clamp the magnitude, then put the sign back (truncation toward zero)
  for (genvar k = 0; k < 4; k++) begin : g_out
    logic [QW-1:0] mag_sat;

    assign mag_sat = (ovf[QW][k] || (quot[QW][k] > SAT)) ? SAT : quot[QW][k];

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k] <= neg[QW][k] ? -TW'(mag_sat) : TW'(mag_sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags <= flg[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW];
    end
  end

  `SCH_ASSERT_NOW(a_quo_range_x, clk, rst, out_valid,
    (quo[0] <= SAT_S) && (quo[0] >= NSAT_S) && (quo[1] <= SAT_S) && (quo[1] >= NSAT_S),
    "x-axis fraction outside the saturation range")
  `SCH_ASSERT_NOW(a_quo_range_y, clk, rst, out_valid,
    (quo[2] <= SAT_S) && (quo[2] >= NSAT_S) && (quo[3] <= SAT_S) && (quo[3] >= NSAT_S),
    "y-axis fraction outside the saturation range")

endmodule

`default_nettype wire

### design/sch_merge.sv
//------------------------------------------------------------------------------
// sch_merge
// Intersects the per-axis entry/exit intervals with [0, 1] over three stages
// and registers the final hit flag and entry time.
//------------------------------------------------------------------------------
`default_nettype none

module sch_merge import sch_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire sch_flags_t                          flags,
  input  wire logic signed [TIME_FRAC_BITS+2:0]    quo [4],
  output logic                                     out_valid,
  output logic                                     hit,
  output logic [TIME_FRAC_BITS:0]                  entry_time
);

  localparam int TW = TIME_FRAC_BITS + 3;
  localparam logic signed [TW-1:0] ONE = {3'b001, {TIME_FRAC_BITS{1'b0}}};

  logic signed [TW-1:0] ent_a  [2];
  logic signed [TW-1:0] lve_a  [2];
  logic                 move_a [2];

  logic signed [TW-1:0] ent_r [2];
  logic signed [TW-1:0] lve_r [2];
  logic                 miss1;
  logic                 v1;

  logic signed [TW-1:0] ent_m;
  logic signed [TW-1:0] lve_m;
  logic signed [TW-1:0] entry;
  logic signed [TW-1:0] leave;
  logic                 miss2;
  logic                 v2;

  logic                 hit_c;

  // stage 1: order each axis pair, a still axis leaves [0, 1] alone
  always_comb begin
    move_a[0] = flags.move_x;
    move_a[1] = flags.move_y;
    for (int k = 0; k < 2; k++) begin
      if (quo[2*k] < quo[2*k+1]) begin
        ent_a[k] = quo[2*k];
        lve_a[k] = quo[2*k+1];
      end else begin
        ent_a[k] = quo[2*k+1];
        lve_a[k] = quo[2*k];
      end
      if (!move_a[k]) begin
        ent_a[k] = '0;
        lve_a[k] = ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= ent_a;
      lve_r <= lve_a;
      miss1 <= flags.static_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  // stage 2: latest entry and earliest exit, clipped to the move
  always_comb begin
    ent_m = (ent_r[0] > ent_r[1]) ? ent_r[0] : ent_r[1];
    lve_m = (lve_r[0] < lve_r[1]) ? lve_r[0] : lve_r[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= ent_m[TW-1] ? '0 : ent_m;
      leave <= (lve_m > ONE) ? ONE : lve_m;
      miss2 <= miss1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  // stage 3: result register, touching bounds count as a hit
  assign hit_c = !miss2 && (entry <= leave);

  always_ff @(posedge clk) begin
    if (en) begin
      hit        <= hit_c;
      entry_time <= hit_c ? entry[TIME_FRAC_BITS:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

endmodule

`default_nettype wire

### design/swept_circle_box_hit_time.sv
//------------------------------------------------------------------------------
// swept_circle_box_hit_time
// Pipeline: prep, a divider that yields one quotient bit per stage over
//   TIME_FRAC_BITS + 2 bits, then merge.
// Throughput: one transaction per cycle; a held result stalls every stage.
// Reset: clears all valid bits and loads the radius with 9.0 pixels.
//------------------------------------------------------------------------------
`default_nettype none

`include "swept_circle_box_hit_time_defines.svh"

module swept_circle_box_hit_time import sch_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // config: radius, q8.4
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [RADIUS_BITS-1:0]                 cfg_data,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // from_x, from_y, to_x, to_y, box_left, box_top, box_width, box_height
  input  wire logic [((8*COORD_BITS-2+7)/8)*8-1:0]    s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // hit, entry_time
  output logic [((TIME_FRAC_BITS+2+7)/8)*8-1:0]       m_tdata
);

  localparam int C      = COORD_BITS;
  localparam int WIDE   = imax(COORD_BITS, RADIUS_BITS);
  localparam int OUT_W  = ((TIME_FRAC_BITS + 2 + 7) / 8) * 8;
  localparam logic [TIME_FRAC_BITS:0] ONE_T = {1'b1, {TIME_FRAC_BITS{1'b0}}};

  logic [RADIUS_BITS-1:0] radius;
  logic                   en;

  logic                   prep_valid;
  logic signed [WIDE+2:0] prep_num [4];
  logic signed [C:0]      prep_den [2];
  sch_flags_t             prep_flags;

  logic                          div_valid;
  sch_flags_t                    div_flags;
  logic signed [TIME_FRAC_BITS+2:0] div_quo [4];

  logic                    hit;
  logic [TIME_FRAC_BITS:0] entry_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // the whole pipeline moves unless a finished result is waiting
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  sch_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .from_x     (s_tdata[C-1:0]),
    .from_y     (s_tdata[2*C-1:C]),
    .to_x       (s_tdata[3*C-1:2*C]),
    .to_y       (s_tdata[4*C-1:3*C]),
    .box_left   (s_tdata[5*C-1:4*C]),
    .box_top    (s_tdata[6*C-1:5*C]),
    .box_width  (s_tdata[7*C-2:6*C]),
    .box_height (s_tdata[8*C-3:7*C-1]),
    .radius     (radius),
    .out_valid  (prep_valid),
    .num        (prep_num),
    .den        (prep_den),
    .flags      (prep_flags)
  );

  sch_div #(
    .COORD_BITS     (COORD_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .in_flags  (prep_flags),
    .num       (prep_num),
    .den       (prep_den),
    .out_valid (div_valid),
    .out_flags (div_flags),
    .quo       (div_quo)
  );

  sch_merge #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (div_valid),
    .flags      (div_flags),
    .quo        (div_quo),
    .out_valid  (m_tvalid),
    .hit        (hit),
    .entry_time (entry_time)
  );

  assign m_tdata = OUT_W'({entry_time, hit});

  `SCH_ASSERT_NOW(a_miss_zero_time, clk, rst, m_tvalid && !hit, entry_time == '0,
    "miss result carries a nonzero entry time")
  `SCH_ASSERT_NOW(a_time_in_move, clk, rst, m_tvalid && hit, entry_time <= ONE_T,
    "entry time beyond the end of the move")
  `SCH_ASSERT_NOW(a_empty_after_reset, clk, rst, $fell(rst), !m_tvalid,
    "result presented right after reset")

endmodule

`default_nettype wire

### verif/tb_swept_circle_box_hit_time.sv
//------------------------------------------------------------------------------
// tb_swept_circle_box_hit_time
// Streams segment/box tests through the swept circle hit-time block. A
// scoreboard predicts hit and entry time with its own slab test. It checks each
// result in order; in some phases both sides idle at random. It also writes
// the radius register between phases and holds the output off long enough to
// fill the pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_swept_circle_box_hit_time;
  import sch_pkg::*;

  localparam int S_DATA_W       = ((8*COORD_BITS_DEF-2+7)/8)*8;
  localparam int M_DATA_W       = ((TIME_FRAC_BITS_DEF+2+7)/8)*8;
  localparam int DUT_LATENCY    = TIME_FRAC_BITS_DEF + 9;
  localparam longint TIME_ONE   = longint'(1) << TIME_FRAC_BITS_DEF;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CHUNK_ITEMS    = 250;

  typedef struct packed {
    logic [15:0] from_x;
    logic [15:0] from_y;
    logic [15:0] to_x;
    logic [15:0] to_y;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [14:0] box_width;
    logic [14:0] box_height;
  } seg_t;

  typedef struct packed {
    logic        hit;
    logic [16:0] entry_time;
  } hit_result_t;

  class hit_time_scoreboard;
    logic [RADIUS_BITS-1:0] radius;
    hit_result_t            pending_q[$];
    int                     errors;

    function new();
      radius = RADIUS_RESET;
      errors = 0;
    endfunction

    // truncate toward zero, then clamp to +-2.0
    function longint slab_fraction(longint num, longint den);
      longint q;
      q = (num * TIME_ONE) / den;
      if (q > 2 * TIME_ONE) q = 2 * TIME_ONE;
      if (q < -2 * TIME_ONE) q = -2 * TIME_ONE;
      return q;
    endfunction

    function hit_result_t predict(seg_t s);
      longint start_c[2];
      longint delta_c[2];
      longint lo_c[2];
      longint hi_c[2];
      longint entry_t;
      longint leave_t;
      longint a;
      longint b;
      longint swap_t;
      longint r;
      bit hit;
      hit_result_t res;
      r = longint'(radius);
      start_c[0] = longint'($signed(s.from_x));
      start_c[1] = longint'($signed(s.from_y));
      delta_c[0] = longint'($signed(s.to_x)) - start_c[0];
      delta_c[1] = longint'($signed(s.to_y)) - start_c[1];
      lo_c[0] = longint'($signed(s.box_left)) - r;
      lo_c[1] = longint'($signed(s.box_top)) - r;
      hi_c[0] = longint'($signed(s.box_left)) + longint'(s.box_width) + r;
      hi_c[1] = longint'($signed(s.box_top)) + longint'(s.box_height) + r;
      entry_t = 0;
      leave_t = TIME_ONE;
      hit = 1'b1;
      for (int axis = 0; axis < 2 && hit; axis++) begin
        if (delta_c[axis] == 0) begin
          // no motion: the start alone decides this axis
          if (start_c[axis] < lo_c[axis] || start_c[axis] > hi_c[axis]) hit = 1'b0;
        end else begin
          a = slab_fraction(lo_c[axis] - start_c[axis], delta_c[axis]);
          b = slab_fraction(hi_c[axis] - start_c[axis], delta_c[axis]);
          if (a > b) begin
            swap_t = a;
            a = b;
            b = swap_t;
          end
          if (a > entry_t) entry_t = a;
          if (b < leave_t) leave_t = b;
          if (entry_t > leave_t) hit = 1'b0;
        end
      end
      res.hit = hit;
      res.entry_time = hit ? entry_t[16:0] : 17'd0;
      return res;
    endfunction

    function void note_segment(seg_t s);
      pending_q.push_back(predict(s));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic hit, logic [16:0] entry_time);
      hit_result_t exp_r;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result hit=%0b time=%0d", hit, entry_time));
      end else begin
        exp_r = pending_q.pop_front();
        if (hit !== exp_r.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", hit, exp_r.hit));
        if (entry_time !== exp_r.entry_time)
          report_mismatch($sformatf("entry_time %0d, expected %0d",
                                    entry_time, exp_r.entry_time));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [RADIUS_BITS-1:0] cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // from_x, from_y, to_x, to_y, box_left, box_top, box_width, box_height
  logic [S_DATA_W-1:0]    s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // hit, entry_time
  logic [M_DATA_W-1:0]    m_tdata;

  hit_time_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  swept_circle_box_hit_time dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic seg_t seg_of(int fx, int fy, int tx, int ty,
                                  int bl, int bt, int bw, int bh);
    seg_t s;
    s.from_x = 16'(fx);
    s.from_y = 16'(fy);
    s.to_x = 16'(tx);
    s.to_y = 16'(ty);
    s.box_left = 16'(bl);
    s.box_top = 16'(bt);
    s.box_width = 15'(bw);
    s.box_height = 15'(bh);
    return s;
  endfunction

  // mostly segments near the box so both hits and misses stay common
  function automatic seg_t make_random_segment();
    int bl, bt, bw, bh, fx, fy, tx, ty, mode;
    mode = pick(0, 99);
    if (mode < 10)
      return seg_of($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
    bw = (mode < 15) ? 0 : pick(0, 3000);
    bh = (mode > 94) ? 0 : pick(0, 3000);
    if (pick(0, 19) == 0) bw = pick(0, 32767);
    if (pick(0, 19) == 0) bh = pick(0, 32767);
    bl = pick(-20000, 20000);
    bt = pick(-20000, 20000);
    fx = bl + pick(-5000, bw + 5000);
    fy = bt + pick(-5000, bh + 5000);
    tx = bl + pick(-5000, bw + 5000);
    ty = bt + pick(-5000, bh + 5000);
    case (pick(0, 9))
      0: tx = fx;
      1: ty = fy;
      2: tx = fx + pick(-2, 2);
      3: ty = fy + pick(-2, 2);
      default: ;
    endcase
    return seg_of(fx, fy, tx, ty, bl, bt, bw, bh);
  endfunction

  // called at a falling edge, returns at a falling edge
  task send_segment(input seg_t s);
    while (tx_idle_pct != 0 && pick(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {2'b00, s.box_height, s.box_width, s.box_top, s.box_left,
                s.to_y, s.to_x, s.from_y, s.from_x};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_segment(s);
    @(negedge clk);
  endtask

  task wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 5) @(posedge clk);
    @(negedge clk);
  endtask

  task write_radius(input logic [RADIUS_BITS-1:0] val);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.radius = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= (pick(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[0], m_tdata[17:1]);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int chunk;
    logic [RADIUS_BITS-1:0] rad;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset radius (9.0 px = 144)
    send_segment(seg_of(50, 50, 50, 50, 0, 0, 100, 100));          // start inside, static
    send_segment(seg_of(-1000, 50, -1000, 50, 0, 0, 100, 100));    // static x outside
    send_segment(seg_of(50, 2000, 50, 2000, 0, 0, 100, 100));      // static y outside
    send_segment(seg_of(-32768, 50, 32767, 50, 0, 0, 100, 100));   // full sweep right
    send_segment(seg_of(32767, -32768, -32768, 32767, 0, 0, 100, 100));
    send_segment(seg_of(0, 0, 1000, 1000, -32768, -32768, 32767, 32767));
    send_segment(seg_of(-1144, 50, -144, 50, 0, 0, 100, 100));     // touches at t = 1.0
    send_segment(seg_of(-1144, 1244, -144, 244, 0, 0, 100, 100));  // corner, entry = exit
    send_segment(seg_of(-500, 50, -2000, 50, 0, 0, 100, 100));     // moving away
    send_segment(seg_of(-3000, 50, -1000, 50, 0, 0, 100, 100));    // stops short
    send_segment(seg_of(0, 0, 1, 0, 20000, -100, 100, 200));       // tiny step, clamps
    send_segment(seg_of(0, 0, -1, 1, -20000, 0, 100, 100));
    send_segment(seg_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_segment(seg_of(-1, -1, -1, -1, -1, -1, 32767, 32767));
    send_segment(seg_of(-400, -400, 400, 400, 0, 0, 0, 0));        // point box
    send_segment(seg_of(300, 50, 100, 50, 0, 0, 100, 100));        // enters from the right
    send_segment(seg_of(50, -500, 50, 500, 0, 0, 100, 100));
    send_segment(seg_of(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
    s_tvalid <= 1'b0;
    wait_idle();

    for (chunk = 0; chunk < 6; chunk++) begin
      case (chunk / 2)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (chunk)
        0: rad = '0;
        1: rad = '1;
        5: rad = RADIUS_RESET;
        default: rad = RADIUS_BITS'($urandom_range(4095, 0));
      endcase
      write_radius(rad);
      // fill the pipeline against a stalled output
      if (chunk == 4) hold_req = 1'b1;
      repeat (CHUNK_ITEMS) send_segment(make_random_segment());
      s_tvalid <= 1'b0;
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/sch_pkg.sv
design/sch_prep.sv
design/sch_div.sv
design/sch_merge.sv
design/swept_circle_box_hit_time.sv
verif/tb_swept_circle_box_hit_time.sv
